// ----- src/sse_pkg.sv -----
package sse_pkg;

    localparam int DEPTH   = 64;
    localparam int AW      = $clog2(DEPTH);
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int DW      = 32;
    localparam int QDEPTH  = 2;
    localparam int QW      = $clog2(QDEPTH);

    // classified request handed from the front to the back
    typedef struct packed {
        logic [DW-1:0] value;
        logic          last;
    } req_t;

endpackage

// ----- src/sse_ram.sv -----
module sse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/sse_front.sv -----
module sse_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  sse_pkg::req_t in_req,
    output logic          q_valid,
    input  logic          q_ready,
    output sse_pkg::req_t q_req
);
    import sse_pkg::*;

    req_t          buf_reg [QDEPTH];
    logic [QW-1:0] wp_reg, rp_reg;
    logic [QW:0]   cnt_reg;
    logic          push, pop;

    assign in_ready = (cnt_reg != (QW+1)'(QDEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_req    = buf_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wp_reg] <= in_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + QW'(1);
            end
            if (pop)
            begin
                rp_reg <= rp_reg + QW'(1);
            end
            cnt_reg <= cnt_reg + (QW+1)'(push) - (QW+1)'(pop);
        end
    end

endmodule

// ----- src/sse_back.sv -----
module sse_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  sse_pkg::req_t        q_req,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [sse_pkg::DW-1:0] out_value,
    output logic                 out_last,
    output logic                 out_ovf
);
    import sse_pkg::*;

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_GAP   = 4'd1;
    localparam logic [3:0] S_RDI   = 4'd2;
    localparam logic [3:0] S_WTI   = 4'd3;
    localparam logic [3:0] S_RDK   = 4'd4;
    localparam logic [3:0] S_WTK   = 4'd5;
    localparam logic [3:0] S_CMP   = 4'd6;
    localparam logic [3:0] S_ERD   = 4'd7;
    localparam logic [3:0] S_EWT   = 4'd8;
    localparam logic [3:0] S_EOUT  = 4'd9;

    logic [3:0]    st_reg, st_next;
    logic [CW-1:0] n_reg, n_next, gap_reg, gap_next, i_reg, i_next, k_reg, k_next;
    logic [DW-1:0] hold_reg, hold_next;
    logic          drop_reg, drop_next;
    logic          ov_reg, ov_next;
    logic [DW-1:0] ov_val_reg, ov_val_next;
    logic          ov_last_reg, ov_last_next, ov_ovf_reg, ov_ovf_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [DW-1:0] wdata, rdata;
    logic [CW-1:0] kg;

    sse_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign out_valid = ov_reg;
    assign out_value = ov_val_reg;
    assign out_last  = ov_last_reg;
    assign out_ovf   = ov_ovf_reg;
    assign q_ready   = (st_reg == S_LOAD);
    assign kg        = k_reg - gap_reg;

    always_comb
    begin
        st_next      = st_reg;
        n_next       = n_reg;
        gap_next     = gap_reg;
        i_next       = i_reg;
        k_next       = k_reg;
        hold_next    = hold_reg;
        drop_next    = drop_reg;
        ov_next      = ov_reg;
        ov_val_next  = ov_val_reg;
        ov_last_next = ov_last_reg;
        ov_ovf_next  = ov_ovf_reg;
        we           = 1'b0;
        waddr        = n_reg[AW-1:0];
        wdata        = q_req.value;
        raddr        = i_reg[AW-1:0];
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        unique case (st_reg)
            S_LOAD:
            begin
                if (q_valid)
                begin
                    if (n_reg < CW'(DEPTH))
                    begin
                        we     = 1'b1;
                        n_next = n_reg + CW'(1);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (q_req.last)
                    begin
                        st_next = S_GAP;
                        gap_next = ((n_reg < CW'(DEPTH)) ? n_reg + CW'(1) : n_reg) >> 1;
                    end
                end
            end
            S_GAP:
            begin
                if (gap_reg == '0)
                begin
                    i_next  = '0;
                    st_next = S_ERD;
                end
                else
                begin
                    i_next  = gap_reg;
                    st_next = S_RDI;
                end
            end
            S_RDI:
            begin
                // next i of this gap, or halve the gap
                if (i_reg >= n_reg)
                begin
                    gap_next = gap_reg >> 1;
                    st_next  = S_GAP;
                end
                else
                begin
                    raddr   = i_reg[AW-1:0];
                    st_next = S_WTI;
                end
            end
            S_WTI:
            begin
                hold_next = rdata;
                k_next    = i_reg;
                st_next   = S_RDK;
            end
            S_RDK:
            begin
                raddr   = kg[AW-1:0];
                st_next = S_WTK;
            end
            S_WTK:
            begin
                st_next = S_CMP;
                raddr   = kg[AW-1:0];
            end
            S_CMP:
            begin
                waddr = k_reg[AW-1:0];
                we    = 1'b1;
                if ($signed(rdata) > $signed(hold_reg))
                begin
                    wdata  = rdata;
                    k_next = kg;
                    if (kg >= gap_reg)
                    begin
                        st_next = S_RDK;
                    end
                    else
                    begin
                        st_next = S_CMP;
                        // fall through to store hold at k-gap next cycle
                        k_next  = kg;
                        st_next = S_EWT;
                    end
                end
                else
                begin
                    wdata   = hold_reg;
                    i_next  = i_reg + CW'(1);
                    st_next = S_RDI;
                end
            end
            S_EWT:
            begin
                if (gap_reg != '0)
                begin
                    // store hold at position k, then continue with next i
                    we      = 1'b1;
                    waddr   = k_reg[AW-1:0];
                    wdata   = hold_reg;
                    i_next  = i_reg + CW'(1);
                    st_next = S_RDI;
                end
                else
                begin
                    raddr   = i_reg[AW-1:0];
                    st_next = S_EOUT;
                end
            end
            S_ERD:
            begin
                raddr   = i_reg[AW-1:0];
                st_next = S_EWT;
            end
            S_EOUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next      = 1'b1;
                    ov_val_next  = rdata;
                    ov_last_next = (i_reg + CW'(1) == n_reg);
                    ov_ovf_next  = drop_reg;
                    if (i_reg + CW'(1) == n_reg)
                    begin
                        n_next    = '0;
                        drop_next = 1'b0;
                        st_next   = S_LOAD;
                    end
                    else
                    begin
                        i_next  = i_reg + CW'(1);
                        st_next = S_ERD;
                    end
                end
            end
            default:
            begin
                st_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        hold_reg    <= hold_next;
        ov_val_reg  <= ov_val_next;
        ov_last_reg <= ov_last_next;
        ov_ovf_reg  <= ov_ovf_next;
        gap_reg     <= gap_next;
        i_reg       <= i_next;
        k_reg       <= k_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_LOAD;
            n_reg    <= '0;
            drop_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            n_reg    <= n_next;
            drop_reg <= drop_next;
            ov_reg   <= ov_next;
        end
    end

endmodule

// ----- src/shell_sort_engine_core.sv -----
// Shell sort engine.
// s_axis: one signed 32-bit value per request, tlast marks the end of a set.
// m_axis: the set in ascending order, tlast on the final result, tuser is
// the overflow flag (set on every result of a set that lost values).
// Up to DEPTH (64) values are kept in a single-port-write, registered-read
// RAM; extra values are dropped. A two-entry request queue sits between the
// input side and the sort/emit sequencer.
// Values are loaded at one per cycle. On tlast the sequencer runs a Shell
// sort with halving gaps, one compare-move at a time on the RAM port, and
// then emits the results one by one, each read back from the RAM.
// The next set is taken as soon as the last result sits in the output
// register. When the receiver stalls, the output register holds its result
// and the sequencer waits. Reset empties the queue and the stored set.
module shell_sort_engine_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] sorted_value
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // [0] overflow
);
    import sse_pkg::*;

    req_t in_req, q_req;
    logic q_valid, q_ready;

    assign in_req.value = s_axis_tdata;
    assign in_req.last  = s_axis_tlast;

    sse_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_req(in_req),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
    );

    sse_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_value(m_axis_tdata), .out_last(m_axis_tlast), .out_ovf(m_axis_tuser)
    );

endmodule
